// ----- src/rtkv_pkg.sv -----
// Shared constants for the radix-tree key/value map: field widths, command codes
// and the defaults for the top-level parameters. No dependencies.
package rtkv_pkg;

    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CMD_BITS   = 2;

    localparam int DIGIT_BITS_DEFAULT = 4;
    localparam int NODE_POOL_DEFAULT  = 64;

    localparam logic [CMD_BITS-1:0] CMD_GET = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADD = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_DEL = 2'd2;

endpackage

// ----- src/radix_tree_key_value_map.sv -----
// Radix-tree key/value map: sequencer, link and leaf memories, bump allocator.
// Depends on rtkv_pkg.
//
// The key is cut into DIGIT_BITS-wide digits, most significant first; every digit
// but the last follows a child link from the root (node 0), and the last picks a
// value slot in the node reached. Add and delete take missing nodes from a bump
// allocator (never freed); delete stores zero. When the pool runs out the item
// ends with status 1 and value 0, and nodes already taken stay linked. A get on a
// missing path returns 0. Command 3 changes nothing and returns 0, status 0.
// Both memories have one registered read port, so each tree level takes a read
// state and then a check or allocate state. With LEVELS = ceil(16 / DIGIT_BITS),
// an item follows LEVELS - 1 links; then a get reads the value slot and waits for
// its data, while an add or delete writes it. A walk that stops early is shorter.
// s_ready is high only while the sequencer is idle; a finished result waits in the
// output register without holding up the next item, but while it is unread the next
// result holds the sequencer in its done state. After reset a clearing pass writes
// zero to every link and value slot, one a cycle, over 2^(clog2(NODE_POOL) + DIGIT_BITS)
// addresses (1024 at the defaults), and no item is taken until it ends.
module radix_tree_key_value_map #(
    parameter int DIGIT_BITS = rtkv_pkg::DIGIT_BITS_DEFAULT,
    parameter int NODE_POOL  = rtkv_pkg::NODE_POOL_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rtkv_pkg::CMD_BITS-1:0]   s_command,
    input  logic [rtkv_pkg::KEY_BITS-1:0]   s_key,
    input  logic [rtkv_pkg::VALUE_BITS-1:0] s_value_in,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rtkv_pkg::VALUE_BITS-1:0] m_value_out,
    output logic                            m_status
);

    localparam int LEVELS  = (rtkv_pkg::KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int KEY_PAD = LEVELS * DIGIT_BITS;
    localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int NODE_W  = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
    localparam int NF_W    = $clog2(NODE_POOL + 1);
    localparam int ADDR_W  = NODE_W + DIGIT_BITS;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int VW      = rtkv_pkg::VALUE_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINK,
        ST_CHECK,
        ST_LEAF,
        ST_LEAF_WAIT,
        ST_DONE
    } state_t;

    state_t                         state_reg;
    logic [rtkv_pkg::CMD_BITS-1:0]  cmd_reg;
    logic [KEY_PAD-1:0]             key_sh_reg;
    logic [VW-1:0]                  value_reg;
    logic [NODE_W-1:0]              node_reg;
    logic [LVL_W-1:0]               level_reg;
    logic [NF_W-1:0]                next_free_reg;
    logic [ADDR_W-1:0]              clr_cnt_reg;
    logic [VW-1:0]                  res_value_reg;
    logic                           res_status_reg;
    logic                           m_valid_reg;
    logic [VW-1:0]                  m_value_out_reg;
    logic                           m_status_reg;

    // Memories
    logic [NODE_W-1:0] link_mem [DEPTH];
    logic [VW-1:0]     leaf_mem [DEPTH];
    logic [NODE_W-1:0] link_rdata_reg;
    logic [VW-1:0]     leaf_rdata_reg;

    logic [DIGIT_BITS-1:0] digit;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  is_get;
    logic                  pool_full;
    logic                  link_hit;
    logic                  alloc_ok;
    logic                  link_we;
    logic [ADDR_W-1:0]     link_waddr;
    logic [NODE_W-1:0]     link_wdata;
    logic                  leaf_we;
    logic [ADDR_W-1:0]     leaf_waddr;
    logic [VW-1:0]         leaf_wdata;

    assign digit     = key_sh_reg[KEY_PAD-1 -: DIGIT_BITS];
    assign rd_addr   = {node_reg, digit};
    assign is_get    = (cmd_reg == rtkv_pkg::CMD_GET);
    assign pool_full = (next_free_reg == NF_W'(NODE_POOL));
    assign link_hit  = (link_rdata_reg != '0);
    assign alloc_ok  = !is_get && !pool_full;

    always_comb begin
        link_we    = 1'b0;
        link_waddr = rd_addr;
        link_wdata = NODE_W'(next_free_reg);
        leaf_we    = 1'b0;
        leaf_waddr = rd_addr;
        leaf_wdata = (cmd_reg == rtkv_pkg::CMD_ADD) ? value_reg : '0;
        unique case (state_reg)
            ST_CLEAR: begin
                link_we    = 1'b1;
                link_waddr = clr_cnt_reg;
                link_wdata = '0;
                leaf_we    = 1'b1;
                leaf_waddr = clr_cnt_reg;
                leaf_wdata = '0;
            end
            ST_CHECK: begin
                link_we = !link_hit && alloc_ok;
            end
            ST_LEAF: begin
                leaf_we = !is_get;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata_reg <= link_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (leaf_we) begin
            leaf_mem[leaf_waddr] <= leaf_wdata;
        end
        leaf_rdata_reg <= leaf_mem[rd_addr];
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            next_free_reg <= NF_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            // the done state loads the output register itself
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg    <= s_command;
                        key_sh_reg <= KEY_PAD'(s_key);
                        value_reg  <= s_value_in;
                        node_reg   <= '0;
                        level_reg  <= LVL_W'(LEVELS - 1);
                        if (s_command == rtkv_pkg::CMD_GET || s_command == rtkv_pkg::CMD_ADD ||
                            s_command == rtkv_pkg::CMD_DEL) begin
                            state_reg <= ST_LINK;
                        end else begin
                            // unknown command: no effect, empty result
                            res_value_reg  <= '0;
                            res_status_reg <= 1'b0;
                            state_reg      <= ST_DONE;
                        end
                    end
                end
                ST_LINK: begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (link_hit || alloc_ok) begin
                        if (link_hit) begin
                            node_reg <= link_rdata_reg;
                        end else begin
                            node_reg      <= NODE_W'(next_free_reg);
                            next_free_reg <= next_free_reg + 1'b1;
                        end
                        // advance to the next digit
                        key_sh_reg <= key_sh_reg << DIGIT_BITS;
                        level_reg  <= level_reg - 1'b1;
                        if (level_reg == LVL_W'(1)) begin
                            state_reg <= ST_LEAF;
                        end else begin
                            state_reg <= ST_LINK;
                        end
                    end else begin
                        // absent path on get, or pool exhausted on add/delete
                        res_value_reg  <= '0;
                        res_status_reg <= !is_get;
                        state_reg      <= ST_DONE;
                    end
                end
                ST_LEAF: begin
                    res_value_reg  <= '0;
                    res_status_reg <= 1'b0;
                    state_reg      <= is_get ? ST_LEAF_WAIT : ST_DONE;
                end
                ST_LEAF_WAIT: begin
                    res_value_reg <= leaf_rdata_reg;
                    state_reg     <= ST_DONE;
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg     <= 1'b1;
                        m_value_out_reg <= res_value_reg;
                        m_status_reg    <= res_status_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_value_out = m_value_out_reg;
    assign m_status    = m_status_reg;

endmodule

// ----- test/radix_tree_key_value_map_test.sv -----
// Self-checking testbench for radix_tree_key_value_map: random and directed get/add/delete
// and unknown-command items checked against a scoreboard that keeps its own copy of the tree.
// Depends on rtkv_pkg and radix_tree_key_value_map.

typedef struct {
    logic [rtkv_pkg::VALUE_BITS-1:0] value;
    logic                            status;
} map_reply_t;

class map_tracker;
    localparam int DIGIT  = rtkv_pkg::DIGIT_BITS_DEFAULT;
    localparam int POOL   = rtkv_pkg::NODE_POOL_DEFAULT;
    localparam int FANOUT = 1 << DIGIT;
    localparam int LEVELS = (rtkv_pkg::KEY_BITS + DIGIT - 1) / DIGIT;
    localparam int SLOTS  = POOL * FANOUT;
    localparam int NODE_W = $clog2(POOL);

    logic [NODE_W-1:0]               child [SLOTS];
    logic [rtkv_pkg::VALUE_BITS-1:0] leaf [SLOTS];
    int unsigned                     free_node;
    map_reply_t                      replies [$];
    int                              errors;

    function new();
        foreach (child[i]) begin
            child[i] = '0;
            leaf[i]  = '0;
        end
        free_node = 1;
        errors    = 0;
    endfunction

    function int pending();
        return replies.size();
    endfunction

    // Walk the tree as the block does and queue the reply it owes for this item.
    function void note_request(logic [rtkv_pkg::CMD_BITS-1:0] cmd,
                               logic [rtkv_pkg::KEY_BITS-1:0] key,
                               logic [rtkv_pkg::VALUE_BITS-1:0] val);
        map_reply_t r;
        int         node;
        int         slot;
        int         lvl;
        bit         grow;
        bit         found;
        r.value  = '0;
        r.status = 1'b0;
        if (cmd == rtkv_pkg::CMD_GET || cmd == rtkv_pkg::CMD_ADD ||
            cmd == rtkv_pkg::CMD_DEL) begin
            grow  = (cmd != rtkv_pkg::CMD_GET);
            node  = 0;
            found = 1'b1;
            for (lvl = LEVELS - 1; lvl > 0 && found; lvl--) begin
                slot = node * FANOUT + ((key >> (lvl * DIGIT)) & (FANOUT - 1));
                if (child[slot] == '0) begin
                    // nodes taken before the pool runs dry stay linked
                    if (!grow || free_node >= POOL) begin
                        found = 1'b0;
                    end else begin
                        child[slot] = NODE_W'(free_node);
                        free_node++;
                    end
                end
                if (found) node = child[slot];
            end
            slot = node * FANOUT + (key & (FANOUT - 1));
            if (!found) begin
                r.status = grow;
            end else if (cmd == rtkv_pkg::CMD_GET) begin
                r.value = leaf[slot];
            end else begin
                leaf[slot] = (cmd == rtkv_pkg::CMD_ADD) ? val : '0;
            end
        end
        replies.push_back(r);
    endfunction

    function void check_response(logic [rtkv_pkg::VALUE_BITS-1:0] value, logic status);
        map_reply_t want;
        if (replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, got value_out %h status %b",
                     $time, value, status);
            return;
        end
        want = replies.pop_front();
        if (value !== want.value) begin
            errors++;
            $display("%0t: value_out expected %h got %h", $time, want.value, value);
        end
        if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %b got %b", $time, want.status, status);
        end
    endfunction
endclass

module radix_tree_key_value_map_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PERIOD       = 10;
    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PREFIX_BITS  = rtkv_pkg::KEY_BITS - rtkv_pkg::DIGIT_BITS_DEFAULT;
    localparam logic [rtkv_pkg::CMD_BITS-1:0] CMD_NOP = 2'd3;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic [rtkv_pkg::CMD_BITS-1:0]   s_command;
    logic [rtkv_pkg::KEY_BITS-1:0]   s_key;
    logic [rtkv_pkg::VALUE_BITS-1:0] s_value_in;
    logic                            m_valid;
    logic                            m_ready;
    logic [rtkv_pkg::VALUE_BITS-1:0] m_value_out;
    logic                            m_status;

    map_tracker                      tracker;
    logic [rtkv_pkg::KEY_BITS-1:0]   written_keys [$];
    logic [PREFIX_BITS-1:0]          hot_prefix [8];
    int unsigned                     cycle_count = 0;

    radix_tree_key_value_map dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_key       (s_key),
        .s_value_in  (s_value_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_out (m_value_out),
        .m_status    (m_status)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("radix_tree_key_value_map test failed");
            $finish;
        end
    end

    // Mostly keys under a few shared prefixes so that paths get reused.
    function automatic logic [rtkv_pkg::KEY_BITS-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return {hot_prefix[$urandom_range(7)], rtkv_pkg::DIGIT_BITS_DEFAULT'($urandom)};
        if (r < 80 && written_keys.size() != 0)
            return written_keys[$urandom_range(written_keys.size() - 1)];
        return rtkv_pkg::KEY_BITS'($urandom);
    endfunction

    function automatic logic [rtkv_pkg::VALUE_BITS-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return rtkv_pkg::VALUE_BITS'($urandom);
    endfunction

    function automatic logic [rtkv_pkg::CMD_BITS-1:0] pick_command();
        int r;
        r = $urandom_range(99);
        if (r < 35) return rtkv_pkg::CMD_GET;
        if (r < 72) return rtkv_pkg::CMD_ADD;
        if (r < 92) return rtkv_pkg::CMD_DEL;
        return CMD_NOP;
    endfunction

    function automatic int send_gap(int n);
        return ((n / 40) % 3 == 2) ? 0 : $urandom_range(9);
    endfunction

    task automatic offer(input logic [rtkv_pkg::CMD_BITS-1:0] cmd,
                         input logic [rtkv_pkg::KEY_BITS-1:0] key,
                         input logic [rtkv_pkg::VALUE_BITS-1:0] val, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_key      <= key;
        s_value_in <= val;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(cmd, key, val);
        if (cmd == rtkv_pkg::CMD_ADD) written_keys.push_back(key);
    endtask

    // Hold the sender back until every owed reply has come out.
    task automatic drain_replies();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    initial begin : collect_replies
        int got;
        int stall;
        got     = 0;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            // one long hold-off lets the block back up and stall its input
            stall = (got == 200) ? 300 : (((got / 50) % 3 == 1) ? 0 : $urandom_range(9));
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.check_response(m_value_out, m_status);
            got++;
        end
    end

    initial begin : run_items
        int n;
        aclk       = 1'b0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_command  = rtkv_pkg::CMD_GET;
        s_key      = '0;
        s_value_in = '0;
        tracker    = new();
        foreach (hot_prefix[i]) hot_prefix[i] = PREFIX_BITS'($urandom);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: absent paths, extreme keys and values, delete that allocates, unknown op
        offer(rtkv_pkg::CMD_GET, 16'h0000, 32'h0000_0000, 0);
        offer(rtkv_pkg::CMD_ADD, 16'h0000, 32'hFFFF_FFFF, 0);
        offer(rtkv_pkg::CMD_GET, 16'h0000, 32'h0000_0000, $urandom_range(9));
        offer(rtkv_pkg::CMD_ADD, 16'hFFFF, 32'h0000_0001, 0);
        offer(rtkv_pkg::CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, 0);
        offer(rtkv_pkg::CMD_ADD, 16'h0000, 32'h0000_0000, $urandom_range(9));
        offer(rtkv_pkg::CMD_GET, 16'h0000, 32'h0000_0000, 0);
        offer(rtkv_pkg::CMD_DEL, 16'h1234, 32'hFFFF_FFFF, 0);
        offer(rtkv_pkg::CMD_GET, 16'h1234, 32'h0000_0000, $urandom_range(9));
        offer(CMD_NOP, 16'hFFFF, 32'hFFFF_FFFF, 0);
        offer(rtkv_pkg::CMD_GET, 16'hFFFF, 32'h0000_0000, 0);
        offer(rtkv_pkg::CMD_ADD, 16'h8000, 32'h8000_0000, 0);
        offer(rtkv_pkg::CMD_ADD, 16'hFFF0, 32'h5A5A_A5A5, $urandom_range(9));
        offer(rtkv_pkg::CMD_DEL, 16'hFFFF, 32'h0000_0000, 0);
        offer(rtkv_pkg::CMD_GET, 16'hFFFF, 32'h0000_0000, 0);
        offer(rtkv_pkg::CMD_GET, 16'h8000, 32'h0000_0000, 0);
        offer(rtkv_pkg::CMD_GET, 16'hFFF0, 32'h0000_0000, 0);
        offer(rtkv_pkg::CMD_GET, 16'h7FFF, 32'h0000_0000, $urandom_range(9));

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 400) drain_replies();
            offer(pick_command(), pick_key(), pick_value(), send_gap(n));
        end

        drain_replies();
        repeat (40) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("radix_tree_key_value_map test passed");
        else
            $display("radix_tree_key_value_map test failed");
        $finish;
    end
endmodule
